@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro names the label, antecedent and consequent of one property.
// The enclosing scope supplies clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define CHTH_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication
`define CHTH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/chth_pkg.sv @@
// ----------------------------------------------------------------------------
// chth_pkg
// Shared types and constants of the two-way cuckoo hash table.
// ----------------------------------------------------------------------------
package chth_pkg;

   localparam int TABLE_DEPTH  = 1024;
   localparam int KEY_BITS     = 31;
   localparam int IDX_BITS     = $clog2(TABLE_DEPTH);
   localparam int SIZE_BITS    = 11;
   localparam int DISP_BITS    = 12;
   localparam int COUNT_BITS   = 12;
   localparam int WORD_BITS    = KEY_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(KEY_BITS);

   localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(1021);
   localparam logic [DISP_BITS-1:0] DISP_RESET = DISP_BITS'(32);
   localparam logic [SIZE_BITS-1:0] SIZE_MAX   = SIZE_BITS'(TABLE_DEPTH);

   // Register indexes on the configuration port
   localparam logic REG_TABLE_SIZE = 1'b0;
   localparam logic REG_MAX_DISP   = 1'b1;

   typedef enum logic [1:0] {
      OP_SEARCH = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_OTHER  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_MISS = 2'd1,
      ST_DUP  = 2'd2,
      ST_FAIL = 2'd3
   } status_type;

   typedef struct packed {
      op_type               op;
      logic [KEY_BITS-1:0]  key;
   } item_type;

   // Queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      item_type  item;
   } front_out_type;

   // Back end control towards the front end
   typedef struct packed {
      logic pop;
      logic open;
   } back_ctl_type;

endpackage

@@ src/chth_front.sv @@
// ----------------------------------------------------------------------------
// chth_front
// Accepts request beats, folds unknown operations into search and holds
// them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module chth_front import chth_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [KEY_BITS-1:0] req_key,
   input  back_ctl_type        back_ctl,
   output front_out_type       front_out
);

   item_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   item_type   item_new;

   // Classify the operation
   always_comb begin
      item_new.key = req_key;
      case (req_operation)
         OP_INSERT: item_new.op = OP_INSERT;
         OP_DELETE: item_new.op = OP_DELETE;
         default:   item_new.op = OP_SEARCH;
      endcase
   end

   assign req_ready = back_ctl.open && (cnt_ff != 2'd2);
   assign push      = req_valid && req_ready;

   assign front_out.valid = (cnt_ff != 2'd0);
   assign front_out.item  = q_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = back_ctl.pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(back_ctl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the new beat
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_new;
      end
   end

endmodule

@@ src/chth_div.sv @@
// ----------------------------------------------------------------------------
// chth_div
// Restoring divider, one quotient bit per cycle, key-wide dividend by the
// table size. Gives quotient and remainder.
// ----------------------------------------------------------------------------
module chth_div import chth_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [KEY_BITS-1:0]  dividend,
   input  logic [SIZE_BITS-1:0] divisor,
   output logic                 done,
   output logic [KEY_BITS-1:0]  quot,
   output logic [SIZE_BITS-1:0] rem
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [KEY_BITS-1:0]     work_ff, work_in;
   logic [SIZE_BITS-1:0]    rem_ff, rem_in;
   logic [SIZE_BITS-1:0]    dsr_ff, dsr_in;
   logic [SIZE_BITS:0]      trial;
   logic                    ge;

   assign trial = {rem_ff, work_ff[KEY_BITS-1]};
   assign ge    = (trial >= {1'b0, dsr_ff});

   // One restoring step per cycle
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         work_in = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         work_in = {work_ff[KEY_BITS-2:0], ge};
         rem_in  = ge ? SIZE_BITS'(trial - {1'b0, dsr_ff}) : trial[SIZE_BITS-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(KEY_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign done = done_ff;
   assign quot = work_ff;
   assign rem  = rem_ff;

endmodule

@@ src/chth_engine.sv @@
// ----------------------------------------------------------------------------
// chth_engine
// Back end: clears both tables after reset, hashes each queued item with
// the shared divider, looks both slots up and runs the kick walk. Holds
// the result in an output register.
// ----------------------------------------------------------------------------
module chth_engine import chth_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [SIZE_BITS-1:0]   eff_size,
   input  logic [DISP_BITS-1:0]   max_disp,
   input  front_out_type          front_out,
   output back_ctl_type           back_ctl,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [COUNT_BITS-1:0]  rsp_element_count,
   output logic                   rsp_lost_valid,
   output logic [KEY_BITS-1:0]    rsp_lost_key
);

   typedef enum logic [12:0] {
      S_CLEAR  = 13'b0000000000001,
      S_IDLE   = 13'b0000000000010,
      S_HASH1  = 13'b0000000000100,
      S_HASH2  = 13'b0000000001000,
      S_READ   = 13'b0000000010000,
      S_EVAL   = 13'b0000000100000,
      S_KH1    = 13'b0000001000000,
      S_KH2    = 13'b0000010000000,
      S_KRD2   = 13'b0000100000000,
      S_KEV2   = 13'b0001000000000,
      S_KH3    = 13'b0010000000000,
      S_KRD1   = 13'b0100000000000,
      S_KEV1   = 13'b1000000000000
   } state_type;

   // Table word: valid mark over key
   logic [WORD_BITS-1:0] t1_mem [TABLE_DEPTH];
   logic [WORD_BITS-1:0] t2_mem [TABLE_DEPTH];
   logic [WORD_BITS-1:0] t1_q_ff, t2_q_ff;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [KEY_BITS-1:0]    key_ff, key_in;
   logic [KEY_BITS-1:0]    home_ff, home_in;
   logic [IDX_BITS-1:0]    a1_ff, a1_in;
   logic [IDX_BITS-1:0]    a2_ff, a2_in;
   logic [DISP_BITS-1:0]   round_ff, round_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic [IDX_BITS-1:0]    clr_ff, clr_in;
   status_type             res_st_ff, res_st_in;
   logic                   res_lost_ff, res_lost_in;
   logic                   finish;

   logic                   out_valid_ff, out_valid_in;
   status_type             out_st_ff;
   logic [COUNT_BITS-1:0]  out_cnt_ff;
   logic                   out_lost_ff;
   logic [KEY_BITS-1:0]    out_key_ff;

   logic                   t1_we, t2_we;
   logic [IDX_BITS-1:0]    t1_wa, t2_wa;
   logic [WORD_BITS-1:0]   t1_wd, t2_wd;

   logic                   div_start, div_done;
   logic [KEY_BITS-1:0]    div_arg, div_quot;
   logic [SIZE_BITS-1:0]   div_rem;
   logic                   v1, v2, in1, in2;

   chth_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_arg),
      .divisor  (eff_size),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign v1  = t1_q_ff[WORD_BITS-1];
   assign v2  = t2_q_ff[WORD_BITS-1];
   assign in1 = v1 && (t1_q_ff[KEY_BITS-1:0] == key_ff);
   assign in2 = v2 && (t2_q_ff[KEY_BITS-1:0] == key_ff);

   // Sequence one item at a time
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      home_in     = home_ff;
      a1_in       = a1_ff;
      a2_in       = a2_ff;
      round_in    = round_ff;
      count_in    = count_ff;
      clr_in      = clr_ff;
      res_st_in   = res_st_ff;
      res_lost_in = res_lost_ff;
      finish      = 1'b0;
      back_ctl.pop  = 1'b0;
      back_ctl.open = (state_ff != S_CLEAR);
      div_start   = 1'b0;
      div_arg     = home_ff;
      t1_we = 1'b0; t1_wa = a1_ff; t1_wd = {1'b1, home_ff};
      t2_we = 1'b0; t2_wa = a2_ff; t2_wd = {1'b1, home_ff};
      case (state_ff)
         S_CLEAR: begin
            t1_we = 1'b1; t1_wa = clr_ff; t1_wd = '0;
            t2_we = 1'b1; t2_wa = clr_ff; t2_wd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // Hold the next item until the output register frees
            if (front_out.valid && (!out_valid_ff || rsp_ready)) begin
               back_ctl.pop = 1'b1;
               op_in        = front_out.item.op;
               key_in       = front_out.item.key;
               div_arg      = front_out.item.key;
               div_start    = 1'b1;
               res_st_in    = ST_OK;
               res_lost_in  = 1'b0;
               home_in      = '0;
               state_in     = S_HASH1;
            end
         end
         S_HASH1: begin
            if (div_done) begin
               a1_in     = div_rem[IDX_BITS-1:0];
               div_arg   = div_quot;
               div_start = 1'b1;
               state_in  = S_HASH2;
            end
         end
         S_HASH2: begin
            if (div_done) begin
               a2_in    = div_rem[IDX_BITS-1:0];
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            state_in = S_IDLE;
            finish   = 1'b1;
            case (op_ff)
               OP_INSERT: begin
                  if (in1 || in2) begin
                     res_st_in = ST_DUP;
                  end else if (!v1) begin
                     t1_we = 1'b1; t1_wd = {1'b1, key_ff};
                     count_in = count_ff + 1'b1;
                  end else if (!v2) begin
                     t2_we = 1'b1; t2_wd = {1'b1, key_ff};
                     count_in = count_ff + 1'b1;
                  end else begin
                     // Take the first slot and start the kick walk
                     t1_we     = 1'b1; t1_wd = {1'b1, key_ff};
                     home_in   = t1_q_ff[KEY_BITS-1:0];
                     div_arg   = t1_q_ff[KEY_BITS-1:0];
                     div_start = 1'b1;
                     round_in  = '0;
                     finish    = 1'b0;
                     state_in  = S_KH1;
                  end
               end
               OP_DELETE: begin
                  if (in1) begin
                     t1_we = 1'b1; t1_wd = {1'b0, key_ff};
                     count_in = count_ff - 1'b1;
                  end else if (in2) begin
                     t2_we = 1'b1; t2_wd = {1'b0, key_ff};
                     count_in = count_ff - 1'b1;
                  end else begin
                     res_st_in = ST_MISS;
                  end
               end
               default: begin
                  res_st_in = (in1 || in2) ? ST_OK : ST_MISS;
               end
            endcase
         end
         S_KH1: begin
            if (div_done) begin
               div_arg   = div_quot;
               div_start = 1'b1;
               state_in  = S_KH2;
            end
         end
         S_KH2: begin
            if (div_done) begin
               a2_in    = div_rem[IDX_BITS-1:0];
               state_in = S_KRD2;
            end
         end
         S_KRD2: begin
            state_in = S_KEV2;
         end
         S_KEV2: begin
            t2_we = 1'b1;
            if (!v2) begin
               count_in = count_ff + 1'b1;
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               home_in   = t2_q_ff[KEY_BITS-1:0];
               div_arg   = t2_q_ff[KEY_BITS-1:0];
               div_start = 1'b1;
               state_in  = S_KH3;
            end
         end
         S_KH3: begin
            if (div_done) begin
               a1_in    = div_rem[IDX_BITS-1:0];
               state_in = S_KRD1;
            end
         end
         S_KRD1: begin
            state_in = S_KEV1;
         end
         S_KEV1: begin
            t1_we = 1'b1;
            if (!v1) begin
               count_in = count_ff + 1'b1;
               finish   = 1'b1;
               state_in = S_IDLE;
            end else begin
               home_in = t1_q_ff[KEY_BITS-1:0];
               if (round_ff == max_disp) begin
                  // Out of rounds: drop the evicted key
                  res_st_in   = ST_FAIL;
                  res_lost_in = 1'b1;
                  finish      = 1'b1;
                  state_in    = S_IDLE;
               end else begin
                  round_in  = round_ff + 1'b1;
                  div_arg   = t1_q_ff[KEY_BITS-1:0];
                  div_start = 1'b1;
                  state_in  = S_KH1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: load on finish, drop on accepted beat
   always_comb begin
      out_valid_in = out_valid_ff;
      if (finish) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         res_st_ff    <= ST_OK;
         res_lost_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         res_st_ff    <= res_st_in;
         res_lost_ff  <= res_lost_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      key_ff   <= key_in;
      home_ff  <= home_in;
      a1_ff    <= a1_in;
      a2_ff    <= a2_in;
      round_ff <= round_in;
      if (finish) begin
         out_st_ff   <= res_st_in;
         out_cnt_ff  <= count_in;
         out_lost_ff <= res_lost_in;
         out_key_ff  <= res_lost_in ? home_in : '0;
      end
   end

   // Table memories, registered read
   always_ff @(posedge clock) begin
      if (t1_we) begin
         t1_mem[t1_wa] <= t1_wd;
      end
      t1_q_ff <= t1_mem[a1_ff];
   end

   always_ff @(posedge clock) begin
      if (t2_we) begin
         t2_mem[t2_wa] <= t2_wd;
      end
      t2_q_ff <= t2_mem[a2_ff];
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_st_ff;
   assign rsp_element_count = out_cnt_ff;
   assign rsp_lost_valid    = out_lost_ff;
   assign rsp_lost_key      = out_key_ff;

endmodule

@@ src/cuckoo_hash_table.sv @@
// ----------------------------------------------------------------------------
// cuckoo_hash_table
// Two-way cuckoo hash set of keys with search, insert and delete, and a
// register port for table size and kick limit.
//
//   channel   direction  ports
//   req_      in         req_operation, req_key
//   rsp_      out        rsp_status, rsp_element_count, rsp_lost_valid,
//                        rsp_lost_key
//   csr_      in/out     APB-style, table_size at 0x0, max_displacements 0x4
//
// A search or delete runs two serial divisions by the table size. An insert
// that kicks adds three divisions and two table reads per kick round.
// After reset a clearing pass sweeps both tables; no request beat is taken
// meanwhile. Two request beats queue ahead of the back end; a result
// waiting in the output register holds off the next item.
// ----------------------------------------------------------------------------
module cuckoo_hash_table import chth_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_operation,
   input  logic [KEY_BITS-1:0]    req_key,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [COUNT_BITS-1:0]  rsp_element_count,
   output logic                   rsp_lost_valid,
   output logic [KEY_BITS-1:0]    rsp_lost_key,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);

   logic [SIZE_BITS-1:0] size_ff, size_in;
   logic [DISP_BITS-1:0] disp_ff, disp_in;
   logic [SIZE_BITS-1:0] eff_size;
   logic                 csr_wr;
   front_out_type        front_out;
   back_ctl_type         back_ctl;

   // Register writes
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      size_in = size_ff;
      disp_in = disp_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_TABLE_SIZE: size_in = csr_pwdata[SIZE_BITS-1:0];
            REG_MAX_DISP:   disp_in = csr_pwdata[DISP_BITS-1:0];
            default:        size_in = size_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
         disp_ff <= DISP_RESET;
      end else begin
         size_ff <= size_in;
         disp_ff <= disp_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_MAX_DISP) ? 32'(disp_ff) : 32'(size_ff);

   // Clamp the size into one to table depth
   always_comb begin
      if (size_ff == '0) begin
         eff_size = SIZE_BITS'(1);
      end else if (size_ff > SIZE_MAX) begin
         eff_size = SIZE_MAX;
      end else begin
         eff_size = size_ff;
      end
   end

   chth_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_key       (req_key),
      .back_ctl      (back_ctl),
      .front_out     (front_out)
   );

   chth_engine u_engine (
      .clock             (clock),
      .reset             (reset),
      .eff_size          (eff_size),
      .max_disp          (disp_ff),
      .front_out         (front_out),
      .back_ctl          (back_ctl),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count),
      .rsp_lost_valid    (rsp_lost_valid),
      .rsp_lost_key      (rsp_lost_key)
   );

endmodule

@@ src/chth_checker.sv @@
// ----------------------------------------------------------------------------
// chth_checker
// Port-level checks of the cuckoo hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module chth_checker import chth_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [1:0]             rsp_status,
   input logic [COUNT_BITS-1:0]  rsp_element_count,
   input logic                   rsp_lost_valid,
   input logic [KEY_BITS-1:0]    rsp_lost_key
);

   logic [COUNT_BITS+KEY_BITS+2:0] rsp_word;

   // Whole result payload in one word
   assign rsp_word = {rsp_status, rsp_element_count, rsp_lost_valid, rsp_lost_key};

   // Stalled result beat holds
   `CHTH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

   // Lost key flagged exactly on failed insert
   `CHTH_ASSERT_IMPL(a_lost_fail, rsp_valid, rsp_lost_valid == (rsp_status == ST_FAIL))

   // Lost key reads zero when none was dropped
   `CHTH_ASSERT_IMPL(a_lost_zero, rsp_valid && !rsp_lost_valid, rsp_lost_key == '0)

   // Request channel closed once reset has just been released, as the clearing pass begins
   `CHTH_ASSERT_IMPL(a_clear_closed, $past(reset), !req_ready)

endmodule

bind cuckoo_hash_table chth_checker u_chth_checker (.*);
